FILE: sv/idr_pkg.sv
// shared types and constants for the 64-bit integer divider
`timescale 1ns / 1ps

package idr_pkg;

  // width of the operand and result ports
  localparam int PORT_W = 64;

  // width of the arithmetic, low bits of each operand port
  localparam int DATA_WIDTH = 64;

  // bit counter width, holds DATA_WIDTH-1
  localparam int CNT_W = $clog2(DATA_WIDTH);

  // operation codes
  localparam logic [1:0] OP_UQUO = 2'd0;
  localparam logic [1:0] OP_UREM = 2'd1;
  localparam logic [1:0] OP_SQUO = 2'd2;
  localparam logic [1:0] OP_SREM = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIV,
    ST_FIX
  } state_t;

  // datapath controls from the sequencer
  typedef struct packed {
    logic load;
    logic absolute;
    logic step;
    logic finish;
  } ctl_t;

endpackage

FILE: sv/idr_ctrl.sv
// sequencer for the iterative divider: load, sign fixup, bit loop, result fixup
`timescale 1ns / 1ps

module idr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output idr_pkg::ctl_t ctl
);
  import idr_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  // state and bit counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next   = state;
    count_next   = count;
    ctl          = '0;
    busy         = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_ABS;
        end
      end
      ST_ABS: begin
        ctl.absolute = 1'b1;
        count_next   = CNT_W'(DATA_WIDTH - 1);
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        ctl.step = 1'b1;
        if (count == '0) begin
          state_next = ST_FIX;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ST_FIX: begin
        ctl.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // the bit loop always starts from the top quotient bit
  assert property (@(posedge clk) disable iff (rst)
    state == ST_ABS |=> state == ST_DIV && count == CNT_W'(DATA_WIDTH - 1))
    else $error("bit loop did not start at the top bit");

  // the loop runs until the counter is spent
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && count != '0) |=> state == ST_DIV)
    else $error("bit loop left early");

  // at most one datapath action per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.absolute, ctl.step, ctl.finish}))
    else $error("overlapping datapath controls");

endmodule

FILE: sv/idr_datapath.sv
// divider datapath: operand registers, shared compare-subtract unit, result fixup
`timescale 1ns / 1ps

module idr_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  idr_pkg::ctl_t              ctl,
  input  logic [1:0]                 op,
  input  logic [idr_pkg::PORT_W-1:0] dividend,
  input  logic [idr_pkg::PORT_W-1:0] divisor,
  output logic [idr_pkg::PORT_W-1:0] result,
  output logic                       divide_by_zero,
  output logic                       done
);
  import idr_pkg::*;

  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] dvs;
  logic                  neg_a;
  logic                  neg_b;
  logic                  neg_res;
  logic                  want_rem;
  logic                  zero_dvs;
  logic [DATA_WIDTH-1:0] res;

  logic [DATA_WIDTH-1:0] a_in;
  logic [DATA_WIDTH-1:0] b_in;
  logic                  in_rem;
  logic                  in_signed;
  logic                  in_na;
  logic                  in_nb;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH+1:0] diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] sel;
  logic [DATA_WIDTH-1:0] res_next;

  // decode the incoming transaction
  always_comb begin
    a_in      = dividend[DATA_WIDTH-1:0];
    b_in      = divisor[DATA_WIDTH-1:0];
    in_rem    = (op == OP_UREM) || (op == OP_SREM);
    in_signed = (op == OP_SQUO) || (op == OP_SREM);
    in_na     = in_signed & a_in[DATA_WIDTH-1];
    in_nb     = in_signed & b_in[DATA_WIDTH-1];
  end

  // shared compare-subtract: one quotient bit per step
  always_comb begin
    rem_sh = {rem, quo[DATA_WIDTH-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    fits   = ~diff[DATA_WIDTH+1];
  end

  // result selection, sign correction and zero divisor values
  always_comb begin
    sel = want_rem ? rem : quo;
    if (zero_dvs) begin
      res_next = want_rem ? '0 : '1;
    end else if (neg_res) begin
      res_next = '0 - sel;
    end else begin
      res_next = sel;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quo      <= a_in;
      dvs      <= b_in;
      rem      <= '0;
      neg_a    <= in_na;
      neg_b    <= in_nb;
      neg_res  <= in_rem ? in_na : (in_na ^ in_nb);
      want_rem <= in_rem;
      zero_dvs <= (b_in == '0);
    end else if (ctl.absolute) begin
      if (neg_a) begin
        quo <= '0 - quo;
      end
      if (neg_b) begin
        dvs <= '0 - dvs;
      end
    end else if (ctl.step) begin
      rem <= fits ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
      quo <= {quo[DATA_WIDTH-2:0], fits};
    end
    if (ctl.finish) begin
      res            <= res_next;
      divide_by_zero <= zero_dvs;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  assign result = PORT_W'(res);

  // a strobe only follows the fixup cycle
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.finish))
    else $error("result strobe without fixup");

  // partial remainder stays below a nonzero divisor through the loop
  assert property (@(posedge clk) disable iff (rst)
    (ctl.step && !zero_dvs) |-> rem < dvs)
    else $error("partial remainder out of range");

  // zero divisor remainder reads as zero
  assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero && want_rem) |-> result == '0)
    else $error("zero divisor remainder not cleared");

endmodule

FILE: sv/int64_divide_remainder.sv
// top level of the signed and unsigned 64-bit integer divider
`timescale 1ns / 1ps

// Usage:
//   Drive op, dividend and divisor and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. op selects the
//   unsigned quotient, unsigned remainder, signed quotient or signed
//   remainder. Only the low DATA_WIDTH bits of the operands are used.
//   busy stays high while the divider works. The result and divide_by_zero
//   are valid for exactly one cycle, marked by done, after operand sign
//   fixup, the bit loop of the shared compare-subtract unit (one quotient bit
//   per step) and result sign fixup, which loads the output register.
//   busy drops while done is shown, so the next transaction can be taken
//   while done is high, but not before.
//   A zero divisor sets divide_by_zero with an all-ones quotient or a zero
//   remainder. The minimum value divided by minus one wraps.
//   Synchronous reset returns the sequencer to idle and clears done.
//   The receiver cannot stall: done is a single-cycle strobe.

module int64_divide_remainder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op,
  input  logic [idr_pkg::PORT_W-1:0] dividend,
  input  logic [idr_pkg::PORT_W-1:0] divisor,
  output logic                       done,
  output logic [idr_pkg::PORT_W-1:0] result,
  output logic                       divide_by_zero
);
  import idr_pkg::*;

  ctl_t ctl;

  // sequencer
  idr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // datapath
  idr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .op             (op),
    .dividend       (dividend),
    .divisor        (divisor),
    .result         (result),
    .divide_by_zero (divide_by_zero),
    .done           (done)
  );

endmodule

FILE: sim/tb.sv
// self-checking testbench for the 64-bit signed and unsigned integer divider
`timescale 1ns / 1ps

module tb;
  import idr_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1030;
  localparam int MAX_REPORTS  = 10;

  typedef logic [PORT_W-1:0] word_t;

  // one expected division outcome
  typedef struct packed {
    word_t value;
    logic  zero_div;
  } div_answer_t;

  // expected quotients and remainders, in order of acceptance
  class division_scoreboard;
    div_answer_t awaited[$];
    int failures;
    int reported;

    function new();
      failures = 0;
      reported = 0;
    endfunction

    function word_t width_mask();
      return {PORT_W{1'b1}} >> (PORT_W - DATA_WIDTH);
    endfunction

    function word_t negate_w(word_t v);
      return (word_t'(0) - v) & width_mask();
    endfunction

    // quotient or remainder of one transaction
    function div_answer_t divide(logic [1:0] code, word_t num, word_t den);
      div_answer_t ans;
      word_t mask, a, b, ua, ub;
      logic want_rem, signed_op, na, nb;
      mask = width_mask();
      a = num & mask;
      b = den & mask;
      want_rem = (code == OP_UREM) || (code == OP_SREM);
      signed_op = (code == OP_SQUO) || (code == OP_SREM);
      ans.zero_div = 1'b0;
      if (b == '0) begin
        ans.value = want_rem ? '0 : mask;
        ans.zero_div = 1'b1;
      end else if (!signed_op) begin
        ans.value = want_rem ? (a % b) : (a / b);
      end else begin
        // divide magnitudes, then restore signs
        na = a[DATA_WIDTH-1];
        nb = b[DATA_WIDTH-1];
        ua = na ? negate_w(a) : a;
        ub = nb ? negate_w(b) : b;
        if (want_rem) begin
          ans.value = na ? negate_w(ua % ub) : (ua % ub);
        end else begin
          ans.value = (na != nb) ? negate_w(ua / ub) : (ua / ub);
        end
      end
      ans.value = ans.value & mask;
      return ans;
    endfunction

    function void note_input(logic [1:0] code, word_t num, word_t den);
      awaited.push_back(divide(code, num, den));
    endfunction

    function void check_result(word_t value, logic zero_div);
      div_answer_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("unexpected result %h divide_by_zero %b", value, zero_div);
        end
        return;
      end
      want = awaited.pop_front();
      if (want.value !== value || want.zero_div !== zero_div) begin
        failures++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("mismatch: expected result %h divide_by_zero %b, got result %h divide_by_zero %b",
                   want.value, want.zero_div, value, zero_div);
        end
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] op;
  word_t      dividend;
  word_t      divisor;
  logic       done;
  word_t      result;
  logic       divide_by_zero;

  division_scoreboard sb;
  int burst_left;
  int stall_cycles;

  int64_divide_remainder u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .dividend       (dividend),
    .divisor        (divisor),
    .done           (done),
    .result         (result),
    .divide_by_zero (divide_by_zero)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // monitor: check finished results, record accepted transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result, divide_by_zero);
      if (start && !busy) sb.note_input(op, dividend, divisor);
    end
  end

  function automatic word_t random_word();
    return {$urandom, $urandom};
  endfunction

  // operand mix: full range, short values, negatives, boundaries
  function automatic word_t random_operand();
    word_t v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = random_word();
      3:       v = random_word() >> $urandom_range(0, 63);
      4:       v = word_t'($urandom_range(0, 15));
      5:       v = -word_t'($urandom_range(1, 15));
      6:       v = word_t'(1) << $urandom_range(0, 63);
      default: v = ~word_t'(0) - word_t'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  // drive one transaction and wait until the divider takes it
  task automatic send_division(input logic [1:0] code, input word_t num, input word_t den);
    int gap;
    gap = (burst_left > 0) ? 0 : $urandom_range(0, 11);
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 39) == 0) begin
      burst_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      op <= 2'($urandom);
      dividend <= random_word();
      divisor <= random_word();
      // sometimes let the divider go idle before the gap
      if ($urandom_range(0, 1) == 1) begin
        while (sb.outstanding() != 0) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= code;
    dividend <= num;
    divisor <= den;
    do @(posedge clk); while (busy);
  endtask

  // watchdog on cycles with no accepted transaction or result
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin
    word_t min_val;
    word_t all_ones;
    word_t den;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    op = OP_UQUO;
    dividend = '0;
    divisor = '0;
    burst_left = 0;
    min_val = word_t'(1) << (DATA_WIDTH - 1);
    all_ones = ~word_t'(0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sign combinations
    send_division(OP_UQUO, 100, 7);
    send_division(OP_UREM, 100, 7);
    send_division(OP_SQUO, -word_t'(100), 7);
    send_division(OP_SREM, -word_t'(100), 7);
    send_division(OP_SQUO, 100, -word_t'(7));
    send_division(OP_SREM, 100, -word_t'(7));
    send_division(OP_SQUO, -word_t'(100), -word_t'(7));
    send_division(OP_SREM, -word_t'(100), -word_t'(7));
    // zero divisor on every operation
    send_division(OP_UQUO, 12345, 0);
    send_division(OP_UREM, all_ones, 0);
    send_division(OP_SQUO, min_val, 0);
    send_division(OP_SREM, -word_t'(5), 0);
    // minimum value over minus one
    send_division(OP_SQUO, min_val, all_ones);
    send_division(OP_SREM, min_val, all_ones);
    // range extremes
    send_division(OP_UQUO, all_ones, 1);
    send_division(OP_UREM, all_ones, all_ones);
    send_division(OP_UQUO, 0, all_ones);
    send_division(OP_UQUO, 5, min_val);
    send_division(OP_UREM, all_ones, min_val);
    send_division(OP_SQUO, min_val, 1);
    send_division(OP_SREM, min_val, 3);
    send_division(OP_SQUO, min_val - 1, all_ones);
    send_division(OP_UQUO, min_val, all_ones);
    send_division(OP_SQUO, all_ones, all_ones);

    // random transactions
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      den = ($urandom_range(0, 31) == 0) ? word_t'(0) : random_operand();
      send_division(2'($urandom), random_operand(), den);
    end
    start <= 1'b0;

    // drain
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/idr_pkg.sv
sv/idr_ctrl.sv
sv/idr_datapath.sv
sv/int64_divide_remainder.sv
sim/tb.sv
